// ===== hw/rtl/star_wildcard_matcher_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Star wildcard matcher assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef STAR_WILDCARD_MATCHER_UNIT_MACROS_SVH
`define STAR_WILDCARD_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication.
`define SWM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("star wildcard matcher: same-cycle check failed");

// Next-cycle implication.
`define SWM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("star wildcard matcher: next-cycle check failed");

`endif

// ===== hw/rtl/swm_pkg.sv =====
// ---------------------------------------------------------------------------
// Star wildcard matcher package
// Transaction types, command codes and shared constants.
// ---------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int SWM_PATTERN_MAX = 32;

  localparam logic [7:0] STAR_CH = 8'd42;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_NAME = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic       last;
  } swm_in_t;

  typedef struct packed {
    logic match;
    logic pattern_too_long;
  } swm_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swm_pattern_store.sv =====
// ---------------------------------------------------------------------------
// Star wildcard matcher pattern store
// Holds the pattern bytes, the pattern length and the overflow flag.
// ---------------------------------------------------------------------------
`default_nettype none

module swm_pattern_store #(
  parameter int PATTERN_MAX = swm_pkg::SWM_PATTERN_MAX,
  localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire swm_pkg::swm_in_t             wr_item,
  output logic [PATTERN_MAX-1:0][7:0]       store,
  output logic [PATTERN_MAX-1:0]            star_mask,
  output logic [PATTERN_MAX-1:0]            pos_valid,
  output logic [LEN_W-1:0]                  len,
  output logic                              overflow
);
  import swm_pkg::*;

  logic [PATTERN_MAX-1:0][7:0] store_r;
  logic [LEN_W-1:0]            len_r, len_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        start_new_r, start_new_nxt;
  logic [LEN_W-1:0]            base_len;
  logic                        room;

  // A load that opens a new pattern writes from position zero.
  assign base_len = start_new_r ? '0 : len_r;
  assign room     = (base_len < LEN_W'(PATTERN_MAX));

  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    start_new_nxt = start_new_r;
    if (wr_en) begin
      start_new_nxt = wr_item.last;
      if (room) begin
        len_nxt = base_len + LEN_W'(1);
        ovf_nxt = start_new_r ? 1'b0 : ovf_r;
      end else begin
        len_nxt = base_len;
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      start_new_r <= 1'b1;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      start_new_r <= start_new_nxt;
    end
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (wr_en && room && (base_len == LEN_W'(i))) begin
        store_r[i] <= wr_item.ch;
      end
    end
    assign star_mask[i] = (store_r[i] == STAR_CH);
    assign pos_valid[i] = (LEN_W'(i) < len_r);
  end

  assign store    = store_r;
  assign len      = len_r;
  assign overflow = ovf_r;

endmodule

`default_nettype wire

// ===== hw/rtl/swm_pos_update.sv =====
// ---------------------------------------------------------------------------
// Star wildcard matcher position update
// Closes the active position set over stars and steps it by one name byte.
// ---------------------------------------------------------------------------
`default_nettype none

module swm_pos_update #(
  parameter int PATTERN_MAX = swm_pkg::SWM_PATTERN_MAX,
  localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic [PATTERN_MAX:0]          seed,
  input  wire logic [PATTERN_MAX-1:0][7:0]   store,
  input  wire logic [PATTERN_MAX-1:0]        star_mask,
  input  wire logic [PATTERN_MAX-1:0]        pos_valid,
  input  wire logic [LEN_W-1:0]              len,
  input  wire logic [7:0]                    ch,
  output logic [PATTERN_MAX:0]               seed_nxt,
  output logic                               hit
);
  import swm_pkg::*;

  localparam int LVL = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX:0] closed;
  logic [PATTERN_MAX:0] stay;
  logic [PATTERN_MAX:0] fwd;

  // Star closure as a parallel prefix: p marks spans of stars that carry a
  // reached position forward, doubling the span length at each level.
  always_comb begin
    logic [PATTERN_MAX:0] g;
    logic [PATTERN_MAX:0] p;
    g = seed;
    p = {1'b0, star_mask & pos_valid};
    for (int k = 0; k < LVL; k++) begin
      g = g | ((g & p) << (1 << k));
      p = p & (p >> (1 << k));
    end
    closed = g;
  end

  always_comb begin
    stay = '0;
    fwd  = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      stay[i]   = closed[i] & pos_valid[i] & star_mask[i];
      fwd[i+1]  = closed[i] & pos_valid[i] & ~star_mask[i] & (store[i] == ch);
    end
  end

  assign seed_nxt = stay | fwd;
  assign hit      = closed[len];

endmodule

`default_nettype wire

// ===== hw/rtl/star_wildcard_matcher_unit.sv =====
// ---------------------------------------------------------------------------
// Star wildcard matcher unit
// Whole-name match of streamed bytes against a loaded star-only pattern.
// ---------------------------------------------------------------------------
// The block takes one transaction per cycle while in_stall is low: a pattern
// byte, a name byte or an end of name. Each accepted transaction lands in an
// input register and updates the pattern store and the active position set
// from there when it advances, so an end of name passes the input register
// and then the output register before its verdict shows on out_valid. All
// pattern positions are compared against the name byte in parallel and the
// star closure is a prefix network of ceil(log2(PATTERN_MAX+1)) levels.
// The input register keeps taking transactions while a verdict waits in the
// output register; only an end of name behind a stalled verdict holds off.
`default_nettype none

`include "star_wildcard_matcher_unit_macros.svh"

module star_wildcard_matcher_unit #(
  parameter int PATTERN_MAX = swm_pkg::SWM_PATTERN_MAX
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire swm_pkg::swm_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output swm_pkg::swm_out_t      out_data
);
  import swm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  swm_in_t                     in_r;
  logic                        in_vld_r;
  logic                        adv;
  logic                        is_end;
  logic                        in_accept;

  logic [PATTERN_MAX:0]        seed_r;
  logic [PATTERN_MAX:0]        seed_nxt;
  logic [PATTERN_MAX:0]        step_seed;
  logic                        hit;

  logic [PATTERN_MAX-1:0][7:0] store;
  logic [PATTERN_MAX-1:0]      star_mask;
  logic [PATTERN_MAX-1:0]      pos_valid;
  logic [LEN_W-1:0]            len;
  logic                        overflow;

  swm_out_t                    out_data_r;
  logic                        out_vld_r;

  assign is_end    = (in_r.cmd == CMD_END);
  assign adv       = in_vld_r && !(is_end && out_vld_r && out_stall);
  assign in_stall  = in_vld_r && !adv;
  assign in_accept = in_valid && !in_stall;

  swm_pattern_store #(.PATTERN_MAX(PATTERN_MAX)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (adv && (in_r.cmd == CMD_LOAD)),
    .wr_item   (in_r),
    .store     (store),
    .star_mask (star_mask),
    .pos_valid (pos_valid),
    .len       (len),
    .overflow  (overflow)
  );

  swm_pos_update #(.PATTERN_MAX(PATTERN_MAX)) u_update (
    .seed      (seed_r),
    .store     (store),
    .star_mask (star_mask),
    .pos_valid (pos_valid),
    .len       (len),
    .ch        (in_r.ch),
    .seed_nxt  (step_seed),
    .hit       (hit)
  );

  // The seed is kept before star closure, so a restart is just position zero
  // and the closure is applied against whatever pattern is current.
  always_comb begin
    seed_nxt = seed_r;
    if (adv) begin
      case (in_r.cmd)
        CMD_LOAD: seed_nxt = (PATTERN_MAX + 1)'(1);
        CMD_NAME: seed_nxt = step_seed;
        CMD_END:  seed_nxt = (PATTERN_MAX + 1)'(1);
        default:  seed_nxt = seed_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      seed_r    <= (PATTERN_MAX + 1)'(1);
    end else begin
      seed_r <= seed_nxt;
      if (in_accept) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv && is_end) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
    if (adv && is_end) begin
      out_data_r.match            <= hit && !overflow;
      out_data_r.pattern_too_long <= overflow;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  `SWM_ASSERT_NXT(a_end_gives_verdict, adv && is_end, out_vld_r && (out_data_r.match == $past(hit && !overflow)))
  `SWM_ASSERT_IMP(a_overflow_no_match, out_vld_r, !(out_data_r.match && out_data_r.pattern_too_long))
  `SWM_ASSERT_IMP(a_no_overwrite, out_vld_r && out_stall, !(adv && is_end))
  `SWM_ASSERT_IMP(a_len_in_range, 1'b1, len <= LEN_W'(PATTERN_MAX))

endmodule

`default_nettype wire
